[rtl/core/segment_distance_edge_length_field_core_macros.svh]
// ----------------------------------------------------------------------------
// Segment distance edge length field: assertion macros
// Shared concurrent assertion forms used by the checker.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_DISTANCE_EDGE_LENGTH_FIELD_CORE_MACROS_SVH
`define SEGMENT_DISTANCE_EDGE_LENGTH_FIELD_CORE_MACROS_SVH

// Plain clocked property with reset disable.
`define SDELF_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// A stalled transfer keeps its valid and its payload.
`define SDELF_ASSERT_HOLD(lbl, clk, rstn, vld, stl, dat, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) \
    (vld && stl) |=> (vld && $stable(dat))) else $error(msg);

`endif

[rtl/core/sdelf_pkg.sv]
// ----------------------------------------------------------------------------
// sdelf_pkg
// Types, constants and codes shared by the edge length field core.
// ----------------------------------------------------------------------------
package sdelf_pkg;

  localparam int unsigned MaxLayers = 16;
  localparam int unsigned IdxW      = $clog2(MaxLayers);
  localparam int unsigned CntW      = 5;
  localparam int unsigned SqrtSteps = 36;
  localparam int unsigned DivSteps  = 32;
  localparam int unsigned StepW     = 6;

  localparam logic OP_QUERY = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  typedef struct packed {
    logic               op;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic [3:0]         layer_index;
    logic [31:0]        layer_radius;
    logic [31:0]        layer_horiz_len;
    logic [31:0]        layer_vert_len;
  } in_item_t;

  typedef struct packed {
    logic [31:0] horiz_len;
    logic [31:0] vert_len;
    logic        no_limit;
  } out_item_t;

  typedef struct packed {
    logic [31:0] r;
    logic [31:0] h;
    logic [31:0] v;
  } ent_t;

  typedef enum logic [2:0] {
    CFG_START_X     = 3'd0,
    CFG_START_Y     = 3'd1,
    CFG_START_Z     = 3'd2,
    CFG_END_X       = 3'd3,
    CFG_END_Y       = 3'd4,
    CFG_END_Z       = 3'd5,
    CFG_LAYER_COUNT = 3'd6
  } cfg_idx_e;

  typedef enum logic [2:0] {
    MS_PT_EP,
    MS_SEG,
    MS_DOT,
    MS_ALONG,
    MS_PR,
    MS_INTERP
  } mul_src_e;

  typedef enum logic [1:0] {
    MD_DIST,
    MD_DD,
    MD_DOT,
    MD_PERP
  } mode_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_MSET,
    ST_MUL,
    ST_ACC,
    ST_ASET,
    ST_AMUL,
    ST_PRSV,
    ST_DDSV,
    ST_DDCHK,
    ST_DOTCHK,
    ST_DVI,
    ST_DV,
    ST_SQI,
    ST_SQ,
    ST_RD0,
    ST_C0,
    ST_RDI,
    ST_CI,
    ST_IMS,
    ST_IMUL,
    ST_IDI,
    ST_IDV,
    ST_IRES,
    ST_INNER,
    ST_NEXT,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic            load;
    logic            mem_we;
    logic            mset;
    mul_src_e        msrc;
    logic [1:0]      comp;
    logic            ep;
    logic            mul;
    logic            acc_clr;
    logic            acc_add;
    logic            pr_save;
    logic            dd_save;
    logic            sq_init;
    logic            sq_step;
    logic            div_proj;
    logic            div_int;
    logic            div_step;
    logic            rd_en;
    logic [IdxW-1:0] rd_addr;
    logic            e0_save;
    logic            hi_save;
    logic            lo_save;
    logic            lo_e0;
    logic            sel;
    logic            res_int;
    logic            res_inner;
    logic            out_load;
  } cmd_t;

  typedef struct packed {
    logic            dd_zero;
    logic            acc_neg;
    logic            acc_gt_dd;
    logic            d_le_rd;
    logic [IdxW-1:0] last_idx;
  } status_t;

endpackage

[rtl/core/sdelf_ctrl.sv]
// ----------------------------------------------------------------------------
// sdelf_ctrl
// Sequencer: steps the datapath through distances, table scans,
// interpolation and the projection onto the segment.
// ----------------------------------------------------------------------------
module sdelf_ctrl
  import sdelf_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic    in_op_i,
  output logic    in_stall_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e          state_q, state_d;
  mode_e           mode_q, mode_d;
  logic [1:0]      j_q, j_d;
  logic            ep_q, ep_d;
  logic            seg_q, seg_d;
  logic            found_q, found_d;
  logic            sel_q, sel_d;
  logic [IdxW-1:0] i_q, i_d;
  logic [StepW-1:0] cnt_q, cnt_d;
  logic            out_valid_q, out_valid_d;
  logic            in_acc;
  logic            out_free;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;

  // Next state
  always_comb begin
    state_d = state_q;
    mode_d  = mode_q;
    j_d     = j_q;
    ep_d    = ep_q;
    seg_d   = seg_q;
    found_d = found_q;
    sel_d   = sel_q;
    i_d     = i_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && in_op_i == OP_QUERY) begin
          mode_d  = MD_DIST;
          ep_d    = 1'b0;
          seg_d   = 1'b0;
          j_d     = 2'd0;
          state_d = ST_MSET;
        end
      end
      ST_MSET: state_d = ST_MUL;
      ST_MUL:  state_d = ST_ACC;
      ST_ACC: begin
        if (j_q != 2'd2) begin
          j_d     = j_q + 2'd1;
          state_d = (mode_q == MD_PERP) ? ST_ASET : ST_MSET;
        end else begin
          j_d = 2'd0;
          case (mode_q)
            MD_DIST: state_d = ST_SQI;
            MD_DD:   state_d = ST_DDSV;
            MD_DOT:  state_d = ST_DOTCHK;
            MD_PERP: state_d = ST_SQI;
            default: state_d = ST_SQI;
          endcase
        end
      end
      ST_ASET: state_d = ST_AMUL;
      ST_AMUL: state_d = ST_PRSV;
      ST_PRSV: state_d = ST_MSET;
      ST_DDSV: state_d = ST_DDCHK;
      ST_DDCHK: begin
        if (status_i.dd_zero) begin
          state_d = ST_FIN;
        end else begin
          mode_d  = MD_DOT;
          state_d = ST_MSET;
        end
      end
      ST_DOTCHK: begin
        state_d = (status_i.acc_neg || status_i.acc_gt_dd) ? ST_FIN : ST_DVI;
      end
      ST_DVI: begin
        cnt_d   = '0;
        state_d = ST_DV;
      end
      ST_DV: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == StepW'(DivSteps - 1)) begin
          mode_d  = MD_PERP;
          seg_d   = 1'b1;
          j_d     = 2'd0;
          state_d = ST_ASET;
        end
      end
      ST_SQI: begin
        cnt_d   = '0;
        state_d = ST_SQ;
      end
      ST_SQ: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == StepW'(SqrtSteps - 1)) begin
          state_d = ST_RD0;
        end
      end
      ST_RD0: state_d = ST_C0;
      ST_C0: begin
        if (status_i.d_le_rd) begin
          state_d = ST_INNER;
        end else if (status_i.last_idx == '0) begin
          state_d = ST_NEXT;
        end else begin
          i_d     = status_i.last_idx;
          found_d = 1'b0;
          state_d = ST_RDI;
        end
      end
      ST_RDI: state_d = ST_CI;
      ST_CI: begin
        if (status_i.d_le_rd) begin
          found_d = 1'b1;
          if (i_q == IdxW'(1)) begin
            sel_d   = 1'b0;
            state_d = ST_IMS;
          end else begin
            i_d     = i_q - 1'b1;
            state_d = ST_RDI;
          end
        end else if (found_q) begin
          sel_d   = 1'b0;
          state_d = ST_IMS;
        end else begin
          state_d = ST_NEXT;
        end
      end
      ST_IMS:  state_d = ST_IMUL;
      ST_IMUL: state_d = ST_IDI;
      ST_IDI: begin
        cnt_d   = '0;
        state_d = ST_IDV;
      end
      ST_IDV: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == StepW'(DivSteps - 1)) begin
          state_d = ST_IRES;
        end
      end
      ST_IRES: begin
        if (!sel_q) begin
          sel_d   = 1'b1;
          state_d = ST_IMS;
        end else begin
          state_d = ST_NEXT;
        end
      end
      ST_INNER: begin
        if (seg_q) begin
          state_d = ST_FIN;
        end else begin
          mode_d  = MD_DD;
          j_d     = 2'd0;
          state_d = ST_MSET;
        end
      end
      ST_NEXT: begin
        j_d = 2'd0;
        if (seg_q) begin
          state_d = ST_FIN;
        end else if (!ep_q) begin
          ep_d    = 1'b1;
          mode_d  = MD_DIST;
          state_d = ST_MSET;
        end else begin
          mode_d  = MD_DD;
          state_d = ST_MSET;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o         = '0;
    cmd_o.comp    = j_q;
    cmd_o.ep      = ep_q;
    cmd_o.sel     = sel_q;
    cmd_o.rd_addr = i_q;
    cmd_o.msrc    = MS_PT_EP;
    case (state_q)
      ST_IDLE: begin
        cmd_o.mem_we = in_acc && (in_op_i == OP_WRITE);
        cmd_o.load   = in_acc && (in_op_i == OP_QUERY);
      end
      ST_MSET: begin
        cmd_o.mset = 1'b1;
        case (mode_q)
          MD_DIST: cmd_o.msrc = MS_PT_EP;
          MD_DD:   cmd_o.msrc = MS_SEG;
          MD_DOT:  cmd_o.msrc = MS_DOT;
          MD_PERP: cmd_o.msrc = MS_PR;
          default: cmd_o.msrc = MS_PT_EP;
        endcase
      end
      ST_MUL:  cmd_o.mul = 1'b1;
      ST_ACC:  cmd_o.acc_add = 1'b1;
      ST_ASET: begin
        cmd_o.mset = 1'b1;
        cmd_o.msrc = MS_ALONG;
      end
      ST_AMUL: cmd_o.mul = 1'b1;
      ST_PRSV: cmd_o.pr_save = 1'b1;
      ST_DDSV: begin
        cmd_o.dd_save = 1'b1;
        cmd_o.acc_clr = 1'b1;
      end
      ST_DVI: begin
        cmd_o.div_proj = 1'b1;
        cmd_o.acc_clr  = 1'b1;
      end
      ST_DV:  cmd_o.div_step = 1'b1;
      ST_SQI: begin
        cmd_o.sq_init = 1'b1;
        cmd_o.acc_clr = 1'b1;
      end
      ST_SQ:  cmd_o.sq_step = 1'b1;
      ST_RD0: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_addr = '0;
      end
      ST_C0:  cmd_o.e0_save = 1'b1;
      ST_RDI: cmd_o.rd_en = 1'b1;
      ST_CI: begin
        if (status_i.d_le_rd) begin
          cmd_o.hi_save = 1'b1;
          if (i_q == IdxW'(1)) begin
            cmd_o.lo_save = 1'b1;
            cmd_o.lo_e0   = 1'b1;
          end
        end else begin
          cmd_o.lo_save = 1'b1;
        end
      end
      ST_IMS: begin
        cmd_o.mset = 1'b1;
        cmd_o.msrc = MS_INTERP;
      end
      ST_IMUL:  cmd_o.mul = 1'b1;
      ST_IDI:   cmd_o.div_int = 1'b1;
      ST_IDV:   cmd_o.div_step = 1'b1;
      ST_IRES:  cmd_o.res_int = 1'b1;
      ST_INNER: cmd_o.res_inner = 1'b1;
      ST_FIN:   cmd_o.out_load = out_free;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mode_q      <= MD_DIST;
      j_q         <= '0;
      ep_q        <= 1'b0;
      seg_q       <= 1'b0;
      found_q     <= 1'b0;
      sel_q       <= 1'b0;
      i_q         <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      j_q         <= j_d;
      ep_q        <= ep_d;
      seg_q       <= seg_d;
      found_q     <= found_d;
      sel_q       <= sel_d;
      i_q         <= i_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

[rtl/core/sdelf_dp.sv]
// ----------------------------------------------------------------------------
// sdelf_dp
// Datapath: configuration, layer table, shared multiplier and accumulator,
// bit-serial square root and divider, result and output registers.
// ----------------------------------------------------------------------------
module sdelf_dp
  import sdelf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  in_item_t    in_data_i,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  cmd_t        cmd_i,
  output status_t     status_o,
  output out_item_t   out_data_o
);

  function automatic logic [32:0] mag33(input logic signed [32:0] v);
    return v[32] ? 33'(-v) : 33'(v);
  endfunction

  logic signed [31:0] start_q [3];
  logic signed [31:0] end_q   [3];
  logic [CntW-1:0]    lc_q;
  logic signed [31:0] pt_q    [3];

  ent_t mem_q [MaxLayers];
  ent_t rd_q, e0_q, hi_q, lo_q;

  logic [33:0]        ma_q, mb_q;
  logic               mneg_q, pneg_q;
  logic [67:0]        prod_q;
  logic signed [70:0] acc_q;
  logic signed [34:0] pr_q;
  logic [65:0]        dd_q;
  logic [31:0]        den_q;

  logic [71:0] rad_q;
  logic [38:0] srem_q;
  logic [35:0] d_q;

  logic [65:0] dvr_q, drem_q;
  logic [31:0] dlo_q;
  logic [32:0] dq_q;

  logic [31:0] res_h_q, res_v_q;
  logic        res_unl_q;
  out_item_t   out_q;

  // Component selection
  logic signed [31:0] p_c, s_c, e_c, ep_c;
  logic signed [32:0] pe_diff, v_diff, seg_diff;
  logic [34:0]        pr_abs;
  logic [31:0]        lo_l, hi_l, len_diff, interp_val;
  logic [35:0]        dnum;
  logic [65:0]        rnd;
  logic signed [34:0] along, v_ext;
  logic signed [70:0] prod_s;
  logic [63:0]        nsum;
  logic [65:0]        ip;
  logic               ip_ge;
  logic [38:0]        rem2, trial;
  logic               sq_ge;
  logic [66:0]        dt;
  logic               dv_ge;
  logic [CntW-1:0]    lc_m1;

  always_comb begin
    case (cmd_i.comp)
      2'd0: begin
        p_c = pt_q[0];
        s_c = start_q[0];
        e_c = end_q[0];
      end
      2'd1: begin
        p_c = pt_q[1];
        s_c = start_q[1];
        e_c = end_q[1];
      end
      default: begin
        p_c = pt_q[2];
        s_c = start_q[2];
        e_c = end_q[2];
      end
    endcase
  end

  assign ep_c     = cmd_i.ep ? e_c : s_c;
  assign pe_diff  = 33'(p_c) - 33'(ep_c);
  assign v_diff   = 33'(p_c) - 33'(s_c);
  assign seg_diff = 33'(e_c) - 33'(s_c);
  assign pr_abs   = pr_q[34] ? 35'(-pr_q) : 35'(pr_q);

  assign lo_l       = cmd_i.sel ? lo_q.v : lo_q.h;
  assign hi_l       = cmd_i.sel ? hi_q.v : hi_q.h;
  assign len_diff   = (hi_l >= lo_l) ? (hi_l - lo_l) : (lo_l - hi_l);
  assign dnum       = d_q - {4'b0, lo_q.r};
  assign interp_val = (hi_l >= lo_l) ? (lo_l + dq_q[31:0]) : (lo_l - dq_q[31:0]);

  // Round the along-line product half away from zero to Q16.16
  assign rnd   = {1'b0, prod_q[64:0]} + 66'd2147483648;
  assign along = $signed({1'b0, rnd[65:32]});
  assign v_ext = 35'(v_diff);

  assign prod_s = $signed({3'b000, prod_q});
  assign nsum   = prod_q[63:0] + {33'b0, den_q[31:1]};
  assign ip     = acc_q[65:0];
  assign ip_ge  = (ip >= dd_q);

  assign rem2  = {srem_q[36:0], rad_q[71:70]};
  assign trial = {1'b0, d_q, 2'b01};
  assign sq_ge = (rem2 >= trial);

  assign dt    = {drem_q, dlo_q[31]};
  assign dv_ge = (dt >= {1'b0, dvr_q});

  // Configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 3; k++) begin
        start_q[k] <= '0;
        end_q[k]   <= '0;
      end
      lc_q <= CntW'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_START_X:     start_q[0] <= cfg_data_i;
        CFG_START_Y:     start_q[1] <= cfg_data_i;
        CFG_START_Z:     start_q[2] <= cfg_data_i;
        CFG_END_X:       end_q[0]   <= cfg_data_i;
        CFG_END_Y:       end_q[1]   <= cfg_data_i;
        CFG_END_Z:       end_q[2]   <= cfg_data_i;
        CFG_LAYER_COUNT: lc_q       <= cfg_data_i[CntW-1:0];
        default: ;
      endcase
    end
  end

  // Layer table, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_we) begin
      mem_q[in_data_i.layer_index] <= '{r: in_data_i.layer_radius,
                                        h: in_data_i.layer_horiz_len,
                                        v: in_data_i.layer_vert_len};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rd_q <= mem_q[cmd_i.rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.e0_save) e0_q <= rd_q;
    if (cmd_i.hi_save) hi_q <= rd_q;
    if (cmd_i.lo_save) lo_q <= cmd_i.lo_e0 ? e0_q : rd_q;
  end

  // Point, multiplier, accumulator
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      pt_q[0] <= in_data_i.point_x;
      pt_q[1] <= in_data_i.point_y;
      pt_q[2] <= in_data_i.point_z;
    end
    if (cmd_i.mset) begin
      case (cmd_i.msrc)
        MS_PT_EP: begin
          ma_q   <= {1'b0, mag33(pe_diff)};
          mb_q   <= {1'b0, mag33(pe_diff)};
          mneg_q <= 1'b0;
        end
        MS_SEG: begin
          ma_q   <= {1'b0, mag33(seg_diff)};
          mb_q   <= {1'b0, mag33(seg_diff)};
          mneg_q <= 1'b0;
        end
        MS_DOT: begin
          ma_q   <= {1'b0, mag33(v_diff)};
          mb_q   <= {1'b0, mag33(seg_diff)};
          mneg_q <= v_diff[32] ^ seg_diff[32];
        end
        MS_ALONG: begin
          ma_q   <= {1'b0, mag33(seg_diff)};
          mb_q   <= {1'b0, dq_q};
          mneg_q <= seg_diff[32];
        end
        MS_PR: begin
          ma_q   <= pr_abs[33:0];
          mb_q   <= pr_abs[33:0];
          mneg_q <= 1'b0;
        end
        MS_INTERP: begin
          ma_q   <= {2'b0, len_diff};
          mb_q   <= {2'b0, dnum[31:0]};
          mneg_q <= 1'b0;
          den_q  <= hi_q.r - lo_q.r;
        end
        default: begin
          ma_q   <= '0;
          mb_q   <= '0;
          mneg_q <= 1'b0;
        end
      endcase
    end
    if (cmd_i.mul) begin
      prod_q <= ma_q * mb_q;
      pneg_q <= mneg_q;
    end
    if (cmd_i.pr_save) begin
      pr_q <= pneg_q ? (v_ext + along) : (v_ext - along);
    end
    if (cmd_i.dd_save) begin
      dd_q <= acc_q[65:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load || cmd_i.acc_clr) begin
      acc_q <= '0;
    end else if (cmd_i.acc_add) begin
      acc_q <= pneg_q ? (acc_q - prod_s) : (acc_q + prod_s);
    end
  end

  // Square root, two radicand bits per step
  always_ff @(posedge clk_i) begin
    if (cmd_i.sq_init) begin
      rad_q  <= {2'b00, acc_q[69:0]};
      srem_q <= '0;
      d_q    <= '0;
    end else if (cmd_i.sq_step) begin
      rad_q  <= {rad_q[69:0], 2'b00};
      srem_q <= sq_ge ? (rem2 - trial) : rem2;
      d_q    <= {d_q[34:0], sq_ge};
    end
  end

  // Divider, one quotient bit per step
  always_ff @(posedge clk_i) begin
    if (cmd_i.div_proj) begin
      dvr_q  <= dd_q;
      drem_q <= ip_ge ? (ip - dd_q) : ip;
      dlo_q  <= '0;
      dq_q   <= {32'b0, ip_ge};
    end else if (cmd_i.div_int) begin
      dvr_q  <= {34'b0, den_q};
      drem_q <= {34'b0, nsum[63:32]};
      dlo_q  <= nsum[31:0];
      dq_q   <= '0;
    end else if (cmd_i.div_step) begin
      drem_q <= dv_ge ? 66'(dt - {1'b0, dvr_q}) : dt[65:0];
      dlo_q  <= {dlo_q[30:0], 1'b0};
      dq_q   <= {dq_q[31:0], dv_ge};
    end
  end

  // Running result
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      res_unl_q <= 1'b1;
      res_h_q   <= '0;
      res_v_q   <= '0;
    end else if (cmd_i.res_inner) begin
      if (res_unl_q || e0_q.h < res_h_q) res_h_q <= e0_q.h;
      if (res_unl_q || e0_q.v < res_v_q) res_v_q <= e0_q.v;
      res_unl_q <= 1'b0;
    end else if (cmd_i.res_int) begin
      if (cmd_i.sel) begin
        res_v_q <= interp_val;
      end else begin
        res_h_q <= interp_val;
      end
      res_unl_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.horiz_len <= res_unl_q ? '1 : res_h_q;
      out_q.vert_len  <= res_unl_q ? '1 : res_v_q;
      out_q.no_limit  <= res_unl_q;
    end
  end

  assign out_data_o = out_q;

  // Status
  assign lc_m1 = lc_q - 1'b1;

  always_comb begin
    status_o.dd_zero   = (dd_q == '0);
    status_o.acc_neg   = acc_q[70];
    status_o.acc_gt_dd = (acc_q[69:0] > {4'b0, dd_q});
    status_o.d_le_rd   = (d_q <= {4'b0, rd_q.r});
    if (lc_q == '0) begin
      status_o.last_idx = '0;
    end else if (lc_q > CntW'(MaxLayers)) begin
      status_o.last_idx = IdxW'(MaxLayers - 1);
    end else begin
      status_o.last_idx = lc_m1[IdxW-1:0];
    end
  end

endmodule

[rtl/core/segment_distance_edge_length_field_core.sv]
// ----------------------------------------------------------------------------
// segment_distance_edge_length_field_core
// Allowed mesh edge lengths of a layered size field around a line segment.
// ----------------------------------------------------------------------------
// Work per query: the 36-step square root (up to three per query), the shared
//   32-step divider (projection and two interpolations per scan) and the layer
//   scan, one entry at a time through the single table read port. A finished
//   result waits in the sequencer until the output register is free.
// Throughput: one query at a time; a table write is taken while idle and leaves
//   the block idle.
// Reset: asynchronous, active low; clears the sequencer, output valid and the
//   configuration (endpoints zero, layer count one). The table is not cleared.
// ----------------------------------------------------------------------------
module segment_distance_edge_length_field_core
  import sdelf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // Item channel: queries and layer table writes
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_item_t    in_data_i,
  // Result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_data_o,
  // Configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  cmd_t    cmd;
  status_t status;
  logic    cfg_we;

  // Configuration is taken in any cycle; the user writes it only while idle.
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  // Sequencer: owns the item and result handshakes, walks the datapath through
  // endpoint distances, table scans, interpolation and the segment test.
  sdelf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_op_i     (in_data_i.op),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Datapath: table memory, multiplier, accumulator, square root, divider
  // and the output register that holds a result until its transfer.
  sdelf_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_data_o  (out_data_o)
  );

endmodule

[rtl/core/sdelf_checker.sv]
// ----------------------------------------------------------------------------
// sdelf_checker
// Port-level assertions for the edge length field core.
// ----------------------------------------------------------------------------
`include "segment_distance_edge_length_field_core_macros.svh"

module sdelf_checker
  import sdelf_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input in_item_t    in_data_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input out_item_t   out_data_o,
  input logic        cfg_valid_i,
  input logic        cfg_ready_o,
  input logic [2:0]  cfg_index_i,
  input logic [31:0] cfg_data_i
);

  `SDELF_ASSERT_HOLD(a_out_hold, clk_i, rst_ni, out_valid_o, out_stall_i, out_data_o, "result changed while stalled")
  `SDELF_ASSERT(a_write_one_cycle, clk_i, rst_ni, (in_valid_i && !in_stall_o && in_data_i.op == OP_WRITE) |=> !in_stall_o, "table write held the input")
  `SDELF_ASSERT(a_query_busy, clk_i, rst_ni, (in_valid_i && !in_stall_o && in_data_i.op == OP_QUERY) |=> in_stall_o, "query accepted without going busy")
  `SDELF_ASSERT(a_result_from_work, clk_i, rst_ni, $rose(out_valid_o) |-> $past(in_stall_o), "result appeared without a query in work")

endmodule

bind segment_distance_edge_length_field_core sdelf_checker u_sdelf_checker (.*);

[tb/tb.sv]
// ----------------------------------------------------------------------------
// Edge length field core testbench
// Drives layer table writes and point queries through the item channel, changes
// the segment and layer count between phases, and checks every result against
// a bit-accurate Q16.16 predictor held in a small scoreboard class.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import sdelf_pkg::*;

  localparam logic [2:0] CfgUnused = 3'd7;   // index with no register behind it
  localparam int unsigned SettleCycles = 600;  // beyond the slowest query
  localparam longint unsigned CycleLimit = 4000000;
  localparam int unsigned ItemW = $bits(in_item_t);

  // Scoreboard: shadow copy of the configuration and layer tables, plus the
  // queue of lengths still to come out of the block.
  class edge_len_board;
    logic signed [31:0] seg_s[3];
    logic signed [31:0] seg_e[3];
    logic [4:0]  layer_cnt;
    logic [31:0] rad_tbl[16];
    logic [31:0] hor_tbl[16];
    logic [31:0] ver_tbl[16];
    out_item_t   pending_lengths[$];
    int          errors;
    logic [31:0] lim_h, lim_v;
    bit          unlimited;

    function new();
      for (int k = 0; k < 3; k++) begin
        seg_s[k] = '0;
        seg_e[k] = '0;
      end
      layer_cnt = 5'd1;
      errors = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
        CFG_START_X:     seg_s[0] = val;
        CFG_START_Y:     seg_s[1] = val;
        CFG_START_Z:     seg_s[2] = val;
        CFG_END_X:       seg_e[0] = val;
        CFG_END_Y:       seg_e[1] = val;
        CFG_END_Z:       seg_e[2] = val;
        CFG_LAYER_COUNT: layer_cnt = val[4:0];
        default: ;
      endcase
    endfunction

    function logic [63:0] mag(logic signed [63:0] v);
      return v < 0 ? -v : v;
    endfunction

    function logic [127:0] sum_sq(logic signed [63:0] x, logic signed [63:0] y,
                                  logic signed [63:0] z);
      logic [127:0] a, b, c;
      a = mag(x);
      b = mag(y);
      c = mag(z);
      return a * a + b * b + c * c;
    endfunction

    function logic [63:0] floor_root(logic [127:0] v);
      logic [127:0] r, c;
      r = '0;
      for (int b = 35; b >= 0; b--) begin
        c = r | (128'd1 << b);
        if (c * c <= v) r = c;
      end
      return r[63:0];
    endfunction

    // 0: outside all layers, 1: inside layer 0, 2: interpolate at layer idx
    function int find_layer(logic [63:0] d, output int idx);
      int n, found;
      n = layer_cnt < 1 ? 1 : (layer_cnt > 16 ? 16 : layer_cnt);
      found = 0;
      idx = 0;
      if (d <= {32'b0, rad_tbl[0]}) return 1;
      for (int i = n - 1; i >= 1; i--) begin
        if (d > {32'b0, rad_tbl[i]}) break;
        found = i;
      end
      idx = found;
      return found != 0 ? 2 : 0;
    endfunction

    function logic [31:0] blend(logic [31:0] lo, logic [31:0] hi, int i, logic [63:0] d);
      logic [63:0] num, den, diff, q;
      num  = d - rad_tbl[i-1];
      den  = {32'b0, rad_tbl[i]} - {32'b0, rad_tbl[i-1]};
      diff = hi >= lo ? {32'b0, hi - lo} : {32'b0, lo - hi};
      q    = (diff * num + den / 2) / den;
      return hi >= lo ? lo + q[31:0] : lo - q[31:0];
    endfunction

    function void take_inner();
      if (unlimited || hor_tbl[0] < lim_h) lim_h = hor_tbl[0];
      if (unlimited || ver_tbl[0] < lim_v) lim_v = ver_tbl[0];
      unlimited = 0;
    endfunction

    function void take_blend(int i, logic [63:0] d);
      lim_h = blend(hor_tbl[i-1], hor_tbl[i], i, d);
      lim_v = blend(ver_tbl[i-1], ver_tbl[i], i, d);
      unlimited = 0;
    endfunction

    // Endpoint tests first, then the perpendicular test when the projection
    // lands on a segment of nonzero length.
    function void predict_lengths(logic signed [63:0] pt[3]);
      logic signed [63:0] dv[3], vv[3], pr[3];
      logic [127:0] dd, pos, neg, ip, t, qw;
      logic [63:0]  d, q, a;
      int kind, idx;
      unlimited = 1;
      lim_h = '0;
      lim_v = '0;
      for (int k = 0; k < 3; k++) begin
        dv[k] = 64'(seg_e[k]) - 64'(seg_s[k]);
        vv[k] = pt[k] - 64'(seg_s[k]);
      end
      d = floor_root(sum_sq(pt[0] - seg_s[0], pt[1] - seg_s[1], pt[2] - seg_s[2]));
      kind = find_layer(d, idx);
      if (kind == 1) take_inner();
      else begin
        if (kind == 2) take_blend(idx, d);
        d = floor_root(sum_sq(pt[0] - seg_e[0], pt[1] - seg_e[1], pt[2] - seg_e[2]));
        kind = find_layer(d, idx);
        if (kind == 1) take_inner();
        else if (kind == 2) take_blend(idx, d);
      end
      dd = sum_sq(dv[0], dv[1], dv[2]);
      if (dd == 0) return;
      pos = '0;
      neg = '0;
      for (int k = 0; k < 3; k++) begin
        t = 128'(mag(vv[k])) * 128'(mag(dv[k]));
        if ((vv[k] < 0) != (dv[k] < 0)) neg = neg + t;
        else pos = pos + t;
      end
      if (pos < neg) return;
      ip = pos - neg;
      if (ip > dd) return;
      qw = (ip << 32) / dd;
      q  = qw[63:0];
      for (int k = 0; k < 3; k++) begin
        a = (mag(dv[k]) * q + 64'h8000_0000) >> 32;
        pr[k] = vv[k] - (dv[k] < 0 ? -$signed(a) : $signed(a));
      end
      d = floor_root(sum_sq(pr[0], pr[1], pr[2]));
      kind = find_layer(d, idx);
      if (kind == 1) take_inner();
      else if (kind == 2) take_blend(idx, d);
    endfunction

    function void note_item(in_item_t it);
      logic signed [63:0] pt[3];
      out_item_t o;
      if (it.op == OP_WRITE) begin
        rad_tbl[it.layer_index] = it.layer_radius;
        hor_tbl[it.layer_index] = it.layer_horiz_len;
        ver_tbl[it.layer_index] = it.layer_vert_len;
        return;
      end
      pt[0] = $signed(it.point_x);
      pt[1] = $signed(it.point_y);
      pt[2] = $signed(it.point_z);
      predict_lengths(pt);
      o.horiz_len = unlimited ? 32'hFFFF_FFFF : lim_h;
      o.vert_len  = unlimited ? 32'hFFFF_FFFF : lim_v;
      o.no_limit  = unlimited;
      pending_lengths.push_back(o);
    endfunction

    function void check_lengths(out_item_t got);
      out_item_t want;
      if (pending_lengths.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      want = pending_lengths.pop_front();
      if (got.horiz_len !== want.horiz_len) begin
        $display("%0t: horiz_len expected %h actual %h", $time, want.horiz_len,
                 got.horiz_len);
        errors++;
      end
      if (got.vert_len !== want.vert_len) begin
        $display("%0t: vert_len expected %h actual %h", $time, want.vert_len,
                 got.vert_len);
        errors++;
      end
      if (got.no_limit !== want.no_limit) begin
        $display("%0t: no_limit expected %b actual %b", $time, want.no_limit,
                 got.no_limit);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  in_item_t    in_data_i;
  logic        out_valid_o;
  logic        out_stall_i;
  out_item_t   out_data_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i;
  logic [31:0] cfg_data_i;

  edge_len_board board;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_req;
  int hold_left;
  longint unsigned cycles;
  longint unsigned field_span;   // outer radius of the current layer set

  segment_distance_edge_length_field_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Watchdog: end the run if the block hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Result side: check each transfer, then pick the stall for the next edge.
  // A hold request from the stimulus turns into a long counted stall here.
  always @(posedge clk) begin
    if (rst_ni && out_valid_o && !out_stall_i) board.check_lengths(out_data_o);
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Offer one item; valid stays high into the next call unless a gap is drawn.
  task automatic send_item(in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk); while (in_stall_o);
    board.note_item(it);
  endtask

  // Valid stays high so writes can follow back to back; the caller drops it.
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk); while (!cfg_ready_o);
    board.write_reg(idx, val);
  endtask

  // Wait for every expected result, then, if asked, let the block settle.
  task automatic drain_results(bit settle);
    in_valid_i <= 1'b0;
    @(posedge clk);
    while (board.pending_lengths.size() != 0) @(posedge clk);
    if (settle) repeat (SettleCycles) @(posedge clk);
  endtask

  function automatic in_item_t random_item();
    in_item_t it;
    it = ItemW'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    return it;
  endfunction

  function automatic logic [31:0] clip32(longint unsigned v);
    return v > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  task automatic send_layer(int idx, logic [31:0] r, logic [31:0] h, logic [31:0] v);
    in_item_t it;
    it = random_item();
    it.op = OP_WRITE;
    it.layer_index = idx[3:0];
    it.layer_radius = r;
    it.layer_horiz_len = h;
    it.layer_vert_len = v;
    send_item(it);
  endtask

  // Rewrite all sixteen layers with growing radii on a scale of 2^sc; now and
  // then drop in a random entry to break the ordering.
  task automatic send_layer_set(int sc);
    longint unsigned r, step;
    logic [31:0] h;
    step = 64'd1 << sc;
    r = $urandom_range(0, step[31:0]);
    h = $urandom;
    for (int i = 0; i < 16; i++) begin
      if ($urandom_range(7) == 0) begin
        send_layer(i, $urandom, $urandom, $urandom);
      end else begin
        send_layer(i, clip32(r), h, $urandom);
      end
      r = r + $urandom_range(0, step[31:0]);
      h = $urandom_range(0, 3) == 0 ? $urandom : h + ($urandom >> $urandom_range(1, 31));
    end
    field_span = r > 64'hFFFF_FFFF ? 64'hFFFF_FFFF : r;
  endtask

  // Query near an endpoint, near a point on the segment, or anywhere at all.
  task automatic send_query();
    in_item_t it;
    longint signed base[3], off;
    longint unsigned w;
    int pick, frac;
    it = random_item();
    it.op = OP_QUERY;
    pick = $urandom_range(0, 5);
    frac = $urandom_range(0, 1024);
    if (pick < 5) begin
      for (int k = 0; k < 3; k++) begin
        case (pick)
          0:       base[k] = board.seg_s[k];
          1:       base[k] = board.seg_e[k];
          default: base[k] = board.seg_s[k]
                     + ((64'(board.seg_e[k]) - 64'(board.seg_s[k])) * frac) / 1024;
        endcase
        w = {$urandom, $urandom};
        off = longint'(w % (2 * field_span + 1)) - longint'(field_span);
        if ($urandom_range(0, 3) == 0) off = off / 16;
        base[k] = base[k] + off;
      end
      it.point_x = base[0][31:0];
      it.point_y = base[1][31:0];
      it.point_z = base[2][31:0];
    end
    send_item(it);
  endtask

  task automatic set_segment(logic [31:0] s[3], logic [31:0] e[3], logic [4:0] cnt);
    write_reg(CFG_START_X, s[0]);
    write_reg(CFG_START_Y, s[1]);
    write_reg(CFG_START_Z, s[2]);
    write_reg(CFG_END_X, e[0]);
    write_reg(CFG_END_Y, e[1]);
    write_reg(CFG_END_Z, e[2]);
    write_reg(CFG_LAYER_COUNT, {27'b0, cnt});
  endtask

  initial begin
    logic [31:0] s[3], e[3];
    logic [4:0] cnt;
    in_item_t it;
    int sc;
    board = new();
    cycles = 0;
    send_idle_pct = 6;
    recv_idle_pct = 6;
    hold_req = 0;
    hold_left = 0;
    field_span = 64'd1 << 20;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    out_stall_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    repeat (9) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    // Directed: fill every layer, then probe the reset segment (zero length,
    // layer count one) at the endpoints, far away and at the field extremes.
    for (int i = 0; i < 16; i++) begin
      send_layer(i, 32'((i + 1) << 20), 32'h0010_0000 * (16 - i), 32'h0008_0000 * (i + 1));
    end
    it = random_item();
    it.op = OP_QUERY;
    it.point_x = '0; it.point_y = '0; it.point_z = '0;
    send_item(it);
    it.point_x = 32'h0001_0000;
    send_item(it);
    it.point_x = 32'h7FFF_FFFF; it.point_y = 32'h7FFF_FFFF; it.point_z = 32'h7FFF_FFFF;
    send_item(it);
    it.point_x = 32'h8000_0000; it.point_y = 32'h8000_0000; it.point_z = 32'h8000_0000;
    send_item(it);
    it.point_x = 32'h0000_8000; it.point_y = 32'hFFFF_8000; it.point_z = '0;
    send_item(it);
    drain_results(1);

    // Same layers, a real segment with all sixteen layers: hits inside layer 0,
    // interpolation between layers, and points above the middle of the segment.
    s = '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000};
    e = '{32'h0040_0000, 32'h0000_0000, 32'h0000_0000};
    set_segment(s, e, 5'd16);
    write_reg(CfgUnused, $urandom);
    cfg_valid_i <= 1'b0;
    it.point_x = 32'h0040_0000; it.point_y = '0; it.point_z = '0;
    send_item(it);
    it.point_x = 32'h0020_0000; it.point_y = 32'h0028_0000;
    send_item(it);
    it.point_x = 32'h0020_0000; it.point_y = 32'h00F8_0000;
    send_item(it);
    it.point_x = 32'hFFE0_0000; it.point_y = 32'h0003_0000;
    send_item(it);
    drain_results(1);

    // Random phases, each with its own segment, count and layer set.
    for (int ph = 0; ph < 8; ph++) begin
      sc = $urandom_range(8, 30);
      for (int k = 0; k < 3; k++) begin
        s[k] = $urandom >> (31 - sc);
        e[k] = s[k] + (($urandom >> (31 - sc)) - (32'd1 << sc));
      end
      cnt = 5'($urandom_range(1, 16));
      case (ph)
        0: cnt = 5'd16;
        1: begin cnt = 5'd0; e = s; end     // zero length segment, count zero
        2: begin
          cnt = 5'd31;
          s = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
          e = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
          sc = 31;
        end
        3: cnt = 5'd1;
        default: ;
      endcase
      set_segment(s, e, cnt);
      cfg_valid_i <= 1'b0;
      send_idle_pct = ph == 4 ? 0 : 6;   // one stretch with no gaps at all
      recv_idle_pct = ph == 4 ? 0 : 6;
      send_layer_set(sc > 29 ? 29 : sc);
      if (ph == 5) hold_req = 3000;      // back up the output, keep offering
      for (int n = 0; n < 80; n++) begin
        if (ph == 6 && n == 40) drain_results(0);  // sender waits for all results
        if ($urandom_range(0, 9) == 0) begin
          send_layer($urandom_range(0, 15), $urandom, $urandom, $urandom);
        end else begin
          send_query();
        end
      end
      drain_results(1);
    end

    if (board.errors == 0 && board.pending_lengths.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/sdelf_pkg.sv
rtl/core/sdelf_ctrl.sv
rtl/core/sdelf_dp.sv
rtl/core/segment_distance_edge_length_field_core.sv
rtl/core/sdelf_checker.sv
tb/tb.sv
